// File: sv/bmprle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types and constants of the BMP RLE8 decoder: register widths,
// finish reason codes and the run descriptor that leaves the decode step.
// ----------------------------------------------------------------------------
package bmprle_pkg;

    // Configuration register width and bus address width
    localparam int REG_W   = 31;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Default width of the byte budget counters
    localparam int BUDGET_WIDTH_DEF = 32;

    // Finish reason codes
    localparam logic [1:0] FIN_EOB = 2'd0;   // end-of-bitmap escape
    localparam logic [1:0] FIN_OUT = 2'd1;   // output budget spent
    localparam logic [1:0] FIN_IN  = 2'd2;   // input budget spent

    // Configuration register contents
    typedef struct packed {
        logic [REG_W-1:0] output_limit;
        logic [REG_W-1:0] input_length;
    } cfg_t;

    // One run descriptor
    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] repeat_count;
        logic       line_end;
        logic       finished;
        logic [1:0] finish_reason;
    } run_t;

endpackage

// File: sv/bmprle_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_apb_regs
// APB register file holding the output byte budget and the compressed
// input byte budget.
// ----------------------------------------------------------------------------
module bmprle_apb_regs
    import bmprle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    localparam logic REG_OUTPUT_LIMIT = 1'b0;
    localparam logic REG_INPUT_LENGTH = 1'b1;

    logic             reg_sel;
    logic             wr_en;
    logic [REG_W-1:0] output_limit_reg;
    logic [REG_W-1:0] input_length_reg;

    // Decode the word address
    assign reg_sel = paddr[ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write on the access phase of a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_limit_reg <= '0;
            input_length_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_OUTPUT_LIMIT: output_limit_reg <= pwdata[REG_W-1:0];
                REG_INPUT_LENGTH: input_length_reg <= pwdata[REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            REG_OUTPUT_LIMIT: prdata = DATA_W'(output_limit_reg);
            REG_INPUT_LENGTH: prdata = DATA_W'(input_length_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.output_limit = output_limit_reg;
    assign cfg.input_length = input_length_reg;

endmodule

// File: sv/bmprle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_core
// Decode step of the RLE8 command stream: command phase, held
// count, literal length, line offset and the two byte budget counters.
// ----------------------------------------------------------------------------
module bmprle_core
    import bmprle_pkg::*;
#(
    parameter int BUDGET_WIDTH = BUDGET_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       frame_start,
    input  logic [7:0] code_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output run_t       res
);

    localparam logic [2:0] PH_COUNT   = 3'd0;
    localparam logic [2:0] PH_VALUE   = 3'd1;
    localparam logic [2:0] PH_LITERAL = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam int EW = (BUDGET_WIDTH > REG_W) ? BUDGET_WIDTH : REG_W;
    localparam logic [EW-1:0] BUDGET_MAX = EW'({BUDGET_WIDTH{1'b1}});

    logic [2:0]              phase_reg,    phase_next;
    logic [7:0]              held_reg,     held_next;
    logic [7:0]              lit_reg,      lit_next;
    logic                    pad_reg,      pad_next;
    logic [1:0]              lo_reg,       lo_next;
    logic [BUDGET_WIDTH-1:0] out_rem_reg,  out_rem_next;
    logic [BUDGET_WIDTH-1:0] in_rem_reg,   in_rem_next;

    logic [2:0]              eff_phase;
    logic [1:0]              eff_lo;
    logic [BUDGET_WIDTH-1:0] eff_out;
    logic [BUDGET_WIDTH-1:0] eff_in;
    logic [8:0]              out_amt;
    logic [8:0]              in_amt;
    logic [1:0]              pad_len;

    // Saturate a register value into the counter range
    function automatic logic [BUDGET_WIDTH-1:0] clamp_budget(input logic [REG_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > BUDGET_MAX) ? BUDGET_WIDTH'(BUDGET_MAX) : BUDGET_WIDTH'(ext);
    endfunction

    // Subtract, stopping at zero
    function automatic logic [BUDGET_WIDTH-1:0] sat_sub(input logic [BUDGET_WIDTH-1:0] x,
                                                        input logic [8:0] n);
        logic [BUDGET_WIDTH-1:0] n_ext;
        n_ext = BUDGET_WIDTH'(n);
        return (x > n_ext) ? (x - n_ext) : '0;
    endfunction

    // Start of frame resets the phase and line offset and reloads the budgets
    assign eff_phase = frame_start ? PH_COUNT : phase_reg;
    assign eff_lo    = frame_start ? 2'd0 : lo_reg;
    assign eff_out   = frame_start ? clamp_budget(cfg.output_limit) : out_rem_reg;
    assign eff_in    = frame_start ? clamp_budget(cfg.input_length) : in_rem_reg;
    assign pad_len   = 2'd0 - eff_lo;

    // Decode one byte
    always_comb
    begin
        phase_next = eff_phase;
        held_next  = held_reg;
        lit_next   = lit_reg;
        pad_next   = pad_reg;
        lo_next    = eff_lo;
        out_amt    = '0;
        in_amt     = '0;
        res_valid  = 1'b0;
        res        = '0;

        unique case (eff_phase)
            PH_COUNT:
            begin
                if (eff_out == '0)
                begin
                    phase_next        = PH_DONE;
                    res_valid         = 1'b1;
                    res.finished      = 1'b1;
                    res.finish_reason = FIN_OUT;
                end
                else if (eff_in == '0)
                begin
                    phase_next        = PH_DONE;
                    res_valid         = 1'b1;
                    res.finished      = 1'b1;
                    res.finish_reason = FIN_IN;
                end
                else
                begin
                    held_next  = code_byte;
                    in_amt     = 9'd1;
                    phase_next = PH_VALUE;
                end
            end

            PH_VALUE:
            begin
                in_amt = 9'd1;
                if (held_reg != 8'd0)
                begin
                    // Encoded run
                    out_amt          = {1'b0, held_reg};
                    lo_next          = eff_lo + held_reg[1:0];
                    phase_next       = PH_COUNT;
                    res_valid        = 1'b1;
                    res.pixel_value  = code_byte;
                    res.repeat_count = held_reg;
                end
                else if (code_byte > 8'd2)
                begin
                    // Absolute literal: charge the whole length up front
                    lit_next   = code_byte;
                    pad_next   = code_byte[0];
                    in_amt     = {1'b0, code_byte} + 9'd1;
                    out_amt    = {1'b0, code_byte};
                    lo_next    = eff_lo + code_byte[1:0];
                    phase_next = PH_LITERAL;
                end
                else if (code_byte == 8'd0)
                begin
                    // End of line: pad to a 4-byte offset
                    out_amt          = 9'(pad_len);
                    lo_next          = 2'd0;
                    phase_next       = PH_COUNT;
                    res_valid        = 1'b1;
                    res.repeat_count = 8'(pad_len);
                    res.line_end     = 1'b1;
                end
                else if (code_byte == 8'd1)
                begin
                    // End of bitmap
                    phase_next        = PH_DONE;
                    res_valid         = 1'b1;
                    res.finished      = 1'b1;
                    res.finish_reason = FIN_EOB;
                end
                else
                begin
                    // Delta: consume and drop
                    phase_next = PH_COUNT;
                end
            end

            PH_LITERAL:
            begin
                lit_next         = lit_reg - 8'd1;
                if (lit_next == 8'd0)
                begin
                    phase_next = pad_reg ? PH_PAD : PH_COUNT;
                end
                res_valid        = 1'b1;
                res.pixel_value  = code_byte;
                res.repeat_count = 8'd1;
            end

            PH_PAD:
            begin
                pad_next   = 1'b0;
                phase_next = PH_COUNT;
            end

            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        out_rem_next = sat_sub(eff_out, out_amt);
        in_rem_next  = sat_sub(eff_in, in_amt);
    end

    // Advance the state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            held_reg    <= '0;
            lit_reg     <= '0;
            pad_reg     <= 1'b0;
            lo_reg      <= '0;
            out_rem_reg <= '0;
            in_rem_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            lit_reg     <= lit_next;
            pad_reg     <= pad_next;
            lo_reg      <= lo_next;
            out_rem_reg <= out_rem_next;
            in_rem_reg  <= in_rem_next;
        end
    end

`ifndef SYNTHESIS
    // Once finished, only a frame start brings results back
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !frame_start && phase_reg == PH_DONE) |-> !res_valid)
        else $error("result produced after finish");

    // Every literal byte gives a single-copy run
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !frame_start && phase_reg == PH_LITERAL)
        |-> (res_valid && res.repeat_count == 8'd1))
        else $error("literal byte lost");

    // The pad byte is skipped and returns to command parsing
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !frame_start && phase_reg == PH_PAD)
        |=> (phase_reg == PH_COUNT))
        else $error("pad byte not followed by a command");
`endif

endmodule

// File: sv/bmp_rle8_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_unit
// BMP RLE8 stream decoder: compressed bytes in, run descriptors out.
// ----------------------------------------------------------------------------
// Usage: the decoder takes one compressed byte per cycle while byte_stall is
// low and returns at most one run descriptor (value plus repeat count) per
// byte; each byte passes the input register, then the decode step that writes
// the result register. The decode step with its two byte budget counters is
// the single stage that sets this rate. byte_stall rises only when both the
// input register and the result register are full and run_stall is high.
// Program output_limit (address 0) and input_length (address 4) while idle;
// both budgets are loaded into the counters on a byte with frame_start set,
// not on the register write. After a finish result the decoder drops bytes
// until the next frame_start.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder_unit
    import bmprle_pkg::*;
#(
    parameter int BUDGET_WIDTH = BUDGET_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Compressed byte channel
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic              frame_start,
    input  logic [7:0]        code_byte,
    // Run descriptor channel
    output logic              run_valid,
    input  logic              run_stall,
    output logic [7:0]        pixel_value,
    output logic [7:0]        repeat_count,
    output logic              line_end,
    output logic              finished,
    output logic [1:0]        finish_reason
);

    cfg_t       cfg;
    logic       s1_valid_reg;
    logic       s1_frame_start_reg;
    logic [7:0] s1_code_byte_reg;
    logic       advance;
    logic       step_en;
    logic       res_valid;
    run_t       res;
    logic       run_valid_reg;
    run_t       run_data_reg;

    bmprle_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The decode step moves whenever the result register can take a value
    assign advance    = !run_valid_reg || !run_stall;
    assign step_en    = s1_valid_reg && advance;
    assign byte_stall = s1_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall)
        begin
            s1_frame_start_reg <= frame_start;
            s1_code_byte_reg   <= code_byte;
        end
    end

    bmprle_core #(
        .BUDGET_WIDTH (BUDGET_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .frame_start (s1_frame_start_reg),
        .code_byte   (s1_code_byte_reg),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            run_valid_reg <= s1_valid_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            run_data_reg <= res;
        end
    end

    assign run_valid     = run_valid_reg;
    assign pixel_value   = run_data_reg.pixel_value;
    assign repeat_count  = run_data_reg.repeat_count;
    assign line_end      = run_data_reg.line_end;
    assign finished      = run_data_reg.finished;
    assign finish_reason = run_data_reg.finish_reason;

`ifndef SYNTHESIS
    // Back-pressure on the input comes only from a stalled, full result
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (run_valid && run_stall))
        else $error("input stalled without output back-pressure");

    // A finish result carries no pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid && finished)
        |-> (pixel_value == 8'd0 && repeat_count == 8'd0 && !line_end))
        else $error("finish result carries pixels");

    // A reason is reported only with a finish
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid && !finished) |-> (finish_reason == FIN_EOB))
        else $error("finish reason without finish");

    // Line padding is zeros, at most three of them
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid && line_end)
        |-> (pixel_value == 8'd0 && repeat_count < 8'd4 && !finished))
        else $error("bad end-of-line padding");
`endif

endmodule

// File: tb/bmp_rle8_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_unit_tb
// Self-checking bench for the BMP RLE8 decoder. A byte-level predictor of
// the command decoder and its two byte budgets turns every accepted byte
// into the run descriptor it should produce; a monitor compares each
// descriptor leaving the block, field by field, in order. Directed frames
// cover runs, literals, escapes, budget finishes and frame restarts, then
// random frames built from mostly well-formed commands run under several
// budget settings, with random idle and stall on both channels in all but one.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder_unit_tb;
    import bmprle_pkg::*;

    // Register indexes
    localparam int REG_OUTPUT_LIMIT = 0;
    localparam int REG_INPUT_LENGTH = 1;

    // Command bytes
    localparam logic [7:0] CMD_ESCAPE = 8'd0;
    localparam logic [7:0] ESC_EOL    = 8'd0;
    localparam logic [7:0] ESC_EOB    = 8'd1;
    localparam logic [7:0] ESC_DELTA  = 8'd2;

    localparam logic [31:0] BUDGET_MAX  = 32'hFFFF_FFFF;
    localparam int          SETTLE_CYC  = 8;
    localparam int          CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        WAIT_COUNT,
        WAIT_VALUE,
        IN_LITERAL,
        SKIP_PAD,
        STOPPED
    } dec_phase_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              byte_valid = 1'b0;
    logic              byte_stall;
    logic              frame_start = 1'b0;
    logic [7:0]        code_byte = 8'd0;
    logic              run_valid;
    logic              run_stall = 1'b0;
    logic [7:0]        pixel_value;
    logic [7:0]        repeat_count;
    logic              line_end;
    logic              finished;
    logic [1:0]        finish_reason;

    // Predictor state
    logic [REG_W-1:0] out_limit_reg;
    logic [REG_W-1:0] in_length_reg;
    dec_phase_t       dec_phase;
    logic [7:0]       held_cnt;
    logic [7:0]       lit_left;
    logic             pad_due;
    logic [1:0]       line_pos;
    logic [31:0]      out_left;
    logic [31:0]      in_left;

    run_t expected_runs[$];
    run_t head_run;

    bit idle_enable = 1'b1;
    bit frame_due = 1'b0;
    int errors = 0;
    int live_items = 0;
    int runs_checked = 0;
    int finishes = 0;
    int cycles = 0;

    bmp_rle8_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .frame_start   (frame_start),
        .code_byte     (code_byte),
        .run_valid     (run_valid),
        .run_stall     (run_stall),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .line_end      (line_end),
        .finished      (finished),
        .finish_reason (finish_reason)
    );

    always #5 clk = ~clk;

    // Stall the descriptor channel at random
    always @(posedge clk)
    begin
        run_stall <= idle_enable && ($urandom_range(99) < 21);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d descriptors outstanding",
                     cycles, expected_runs.size());
            $display("** bmp_rle8_decoder_unit: FAILED **");
            $finish;
        end
    end

    // Compare each descriptor transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && run_valid && !run_stall)
        begin
            if (expected_runs.size() == 0)
            begin
                $error("unexpected descriptor: value %0d count %0d eol %0b fin %0b",
                       pixel_value, repeat_count, line_end, finished);
                errors++;
            end
            else
            begin
                head_run = expected_runs.pop_front();
                runs_checked++;
                if (pixel_value !== head_run.pixel_value)
                begin
                    $error("pixel_value: expected %0d, got %0d",
                           head_run.pixel_value, pixel_value);
                    errors++;
                end
                if (repeat_count !== head_run.repeat_count)
                begin
                    $error("repeat_count: expected %0d, got %0d",
                           head_run.repeat_count, repeat_count);
                    errors++;
                end
                if (line_end !== head_run.line_end)
                begin
                    $error("line_end: expected %0b, got %0b", head_run.line_end, line_end);
                    errors++;
                end
                if (finished !== head_run.finished)
                begin
                    $error("finished: expected %0b, got %0b", head_run.finished, finished);
                    errors++;
                end
                if (finish_reason !== head_run.finish_reason)
                begin
                    $error("finish_reason: expected %0d, got %0d",
                           head_run.finish_reason, finish_reason);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] sat_sub(input logic [31:0] x, input logic [31:0] n);
        return (x > n) ? (x - n) : 32'd0;
    endfunction

    // Restart the decoder and load the budgets from the registers
    function automatic void clear_decoder();
        dec_phase = WAIT_COUNT;
        held_cnt  = 8'd0;
        lit_left  = 8'd0;
        pad_due   = 1'b0;
        line_pos  = 2'd0;
        out_left  = {1'b0, out_limit_reg};
        in_left   = {1'b0, in_length_reg};
    endfunction

    // Advance the predicted decoder by one byte; 1 when a descriptor results
    function automatic bit decode_byte(input logic fs, input logic [7:0] b, output run_t run);
        run = '0;
        if (fs)
            clear_decoder();
        case (dec_phase)
            WAIT_COUNT:
            begin
                // Check budgets at the start of each command pair
                if (out_left == 32'd0)
                begin
                    dec_phase = STOPPED;
                    run.finished = 1'b1;
                    run.finish_reason = FIN_OUT;
                    return 1'b1;
                end
                if (in_left == 32'd0)
                begin
                    dec_phase = STOPPED;
                    run.finished = 1'b1;
                    run.finish_reason = FIN_IN;
                    return 1'b1;
                end
                held_cnt = b;
                in_left = sat_sub(in_left, 32'd1);
                dec_phase = WAIT_VALUE;
                return 1'b0;
            end
            WAIT_VALUE:
            begin
                in_left = sat_sub(in_left, 32'd1);
                // Encoded run
                if (held_cnt != 8'd0)
                begin
                    out_left = sat_sub(out_left, {24'd0, held_cnt});
                    line_pos = line_pos + held_cnt[1:0];
                    dec_phase = WAIT_COUNT;
                    run.pixel_value = b;
                    run.repeat_count = held_cnt;
                    return 1'b1;
                end
                // Absolute literal: charge the whole length up front
                if (b > ESC_DELTA)
                begin
                    lit_left = b;
                    pad_due = b[0];
                    in_left = sat_sub(in_left, {24'd0, b});
                    out_left = sat_sub(out_left, {24'd0, b});
                    line_pos = line_pos + b[1:0];
                    dec_phase = IN_LITERAL;
                    return 1'b0;
                end
                // End of line: pad to the next 4-byte offset
                if (b == ESC_EOL)
                begin
                    run.repeat_count = {6'd0, 2'd0 - line_pos};
                    run.line_end = 1'b1;
                    out_left = sat_sub(out_left, {24'd0, run.repeat_count});
                    line_pos = 2'd0;
                    dec_phase = WAIT_COUNT;
                    return 1'b1;
                end
                if (b == ESC_EOB)
                begin
                    dec_phase = STOPPED;
                    run.finished = 1'b1;
                    run.finish_reason = FIN_EOB;
                    return 1'b1;
                end
                // Delta: consume and carry on
                dec_phase = WAIT_COUNT;
                return 1'b0;
            end
            IN_LITERAL:
            begin
                lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0)
                    dec_phase = pad_due ? SKIP_PAD : WAIT_COUNT;
                run.pixel_value = b;
                run.repeat_count = 8'd1;
                return 1'b1;
            end
            SKIP_PAD:
            begin
                pad_due = 1'b0;
                dec_phase = WAIT_COUNT;
                return 1'b0;
            end
            default:
            begin
                dec_phase = STOPPED;
                return 1'b0;
            end
        endcase
    endfunction

    // Send one byte transaction and record what it should produce
    task automatic send_byte(input logic fs_in, input logic [7:0] b);
        logic fs;
        run_t run;
        fs = fs_in | frame_due;
        frame_due = 1'b0;
        if (idle_enable && $urandom_range(99) < 21)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 21)
                @(posedge clk);
        end
        byte_valid  <= 1'b1;
        frame_start <= fs;
        code_byte   <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (fs || dec_phase != STOPPED)
            live_items++;
        if (decode_byte(fs, b, run))
        begin
            expected_runs.push_back(run);
            if (run.finished)
                finishes++;
        end
    endtask

    // Drop valid and let every outstanding descriptor drain
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write one register over the bus and read it back
    task automatic write_reg(input int idx, input logic [31:0] value);
        logic [REG_W-1:0] stored;
        stored = value[REG_W-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_OUTPUT_LIMIT)
            out_limit_reg = stored;
        else if (idx == REG_INPUT_LENGTH)
            in_length_reg = stored;
        // Read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {1'b0, stored})
        begin
            $error("prdata: expected %0h, got %0h", {1'b0, stored}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_budgets(input logic [31:0] out_lim, input logic [31:0] in_len);
        write_reg(REG_OUTPUT_LIMIT, out_lim);
        write_reg(REG_INPUT_LENGTH, in_len);
    endtask

    // Budgets load only on frame_start, not on a register write
    task automatic test_budget_loading();
        set_budgets(32'd1000, 32'd1000);
        send_byte(1'b0, 8'h05);
        send_byte(1'b0, 8'h07);
        send_byte(1'b1, 8'h04);
        send_byte(1'b0, 8'h09);
        wait_idle();
    endtask

    // Every command kind with extreme counts and values
    task automatic test_run_commands();
        set_budgets(BUDGET_MAX, BUDGET_MAX);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h02);
        send_byte(1'b0, 8'hA5);
        // End of line with padding, then at an aligned offset
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, ESC_EOL);
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, ESC_EOL);
        // Odd literal with pad byte, then even literal
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, 8'd3);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h22);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hEE);
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, 8'd4);
        send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h7F);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'hFE);
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, ESC_DELTA);
        send_byte(1'b0, 8'h03);
        send_byte(1'b0, 8'h55);
        send_byte(1'b0, CMD_ESCAPE);
        send_byte(1'b0, ESC_EOB);
        // Ignored after the finish
        send_byte(1'b0, 8'h12);
        wait_idle();
    endtask

    // Budget finishes, literal overrun and restart in mid-command
    task automatic test_byte_budgets();
        // Restart while a value byte is awaited
        send_byte(1'b1, 8'h03);
        send_byte(1'b1, 8'h06);
        send_byte(1'b0, 8'h44);
        wait_idle();
        // Output budget spent exactly
        set_budgets(32'd5, 32'd1000);
        send_byte(1'b1, 8'h03);
        send_byte(1'b0, 8'h10);
        send_byte(1'b0, 8'h02);
        send_byte(1'b0, 8'h20);
        send_byte(1'b0, 8'h07);
        wait_idle();
        // Input budget spent
        set_budgets(32'd1000, 32'd4);
        send_byte(1'b1, 8'h01);
        send_byte(1'b0, 8'hAA);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'hBB);
        send_byte(1'b0, 8'h09);
        wait_idle();
        // Both spent: output wins
        set_budgets(32'd0, 32'd0);
        send_byte(1'b1, 8'h01);
        wait_idle();
        // Literal overruns the output budget, then the input budget runs out
        set_budgets(32'd2, 32'd7);
        send_byte(1'b1, CMD_ESCAPE);
        send_byte(1'b0, 8'd5);
        repeat (5) send_byte(1'b0, 8'($urandom_range(255)));
        send_byte(1'b0, 8'hC3);
        send_byte(1'b0, 8'h01);
        wait_idle();
        set_budgets(32'd1000, 32'd7);
        send_byte(1'b1, CMD_ESCAPE);
        send_byte(1'b0, 8'd5);
        repeat (5) send_byte(1'b0, 8'($urandom_range(255)));
        send_byte(1'b0, 8'h3C);
        send_byte(1'b0, 8'h01);
        wait_idle();
    endtask

    // One random command, mostly well formed
    task automatic send_random_command();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            send_byte(1'b0, 8'(len));
            send_byte(1'b0, 8'($urandom_range(255)));
        end
        else if (kind < 65)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            send_byte(1'b0, CMD_ESCAPE);
            send_byte(1'b0, 8'(len));
            repeat (len) send_byte(1'b0, 8'($urandom_range(255)));
            if (len[0])
                send_byte(1'b0, 8'($urandom_range(255)));
        end
        else if (kind < 78)
        begin
            send_byte(1'b0, CMD_ESCAPE);
            send_byte(1'b0, ESC_EOL);
        end
        else if (kind < 86)
        begin
            send_byte(1'b0, CMD_ESCAPE);
            send_byte(1'b0, ESC_DELTA);
        end
        else if (kind < 89)
        begin
            send_byte(1'b0, CMD_ESCAPE);
            send_byte(1'b0, ESC_EOB);
        end
        else
        begin
            // Noise, now and then a restart in mid-command
            send_byte($urandom_range(24) == 0, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_frames(input int items, input logic [31:0] out_lim,
                                     input logic [31:0] in_len, input bit idle);
        int target;
        set_budgets(out_lim, in_len);
        idle_enable = idle;
        frame_due = 1'b1;
        target = live_items + items;
        while (live_items < target)
        begin
            if (dec_phase == STOPPED || $urandom_range(199) == 0)
                frame_due = 1'b1;
            send_random_command();
        end
        wait_idle();
    endtask

    // Random frames under several budget settings
    task automatic test_random_streams();
        run_random_frames(320, BUDGET_MAX, BUDGET_MAX, 1'b1);
        run_random_frames(310, $urandom_range(16, 600), $urandom_range(16, 600), 1'b1);
        run_random_frames(310, $urandom_range(0, 60), $urandom_range(0, 60), 1'b0);
        run_random_frames(310, $urandom_range(1, 5000), $urandom_range(1, 5000), 1'b1);
        idle_enable = 1'b1;
    endtask

    initial
    begin
        out_limit_reg = '0;
        in_length_reg = '0;
        clear_decoder();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_budget_loading();
        test_run_commands();
        test_byte_budgets();
        test_random_streams();
        wait_idle();

        $display("Decoded %0d live bytes across directed and random frames.", live_items);
        $display("Checked %0d run descriptors, %0d of them finishes; %0d mismatches.",
                 runs_checked, finishes, errors);
        if (errors == 0)
            $display("** bmp_rle8_decoder_unit: PASSED **");
        else
            $display("** bmp_rle8_decoder_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
sv/bmprle_pkg.sv
sv/bmprle_apb_regs.sv
sv/bmprle_core.sv
sv/bmp_rle8_decoder_unit.sv
tb/bmp_rle8_decoder_unit_tb.sv
